### hdl/gbn_pkg.sv
// Shared constants, codes and item types for the go-back-n sender window core.
package gbn_pkg;

    // Packetization
    localparam int PACKET_BYTES = 1024;
    localparam int PKT_SHIFT    = $clog2(PACKET_BYTES);
    localparam int MAX_PACKETS  = 16384;

    // Field widths
    localparam int CNT_W   = 15;
    localparam int TIMER_W = 17;
    localparam int IDX_W   = 14;
    localparam int SEQ_W   = 8;
    localparam int LEN_W   = 11;
    localparam int BYTES_W = 24;
    localparam int WIN_W   = 8;
    localparam int TOUT_W  = 16;
    localparam int WORD_W  = 16;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
    localparam logic [WORD_W-1:0]  CSUM_OK   = 16'hffff;
    localparam logic [7:0]         FLAG_ACK  = 8'h02;

    // Request function codes
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_PASS  = 2'd1;
    localparam logic [1:0] FUNC_ACK   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_WINDOW  = 2'd0;
    localparam logic [1:0] CFG_TOTAL   = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [WIN_W-1:0]   WINDOW_RST  = 8'd4;
    localparam logic [BYTES_W-1:0] TOTAL_RST   = 24'd0;
    localparam logic [TOUT_W-1:0]  TIMEOUT_RST = 16'd500;

    typedef struct packed {
        logic [1:0]        func;
        logic [WORD_W-1:0] ack_length;
        logic [WORD_W-1:0] ack_checksum;
        logic [7:0]        ack_flags;
        logic [SEQ_W-1:0]  ack_seq;
    } item_t;

    typedef struct packed {
        logic              send_valid;
        logic [IDX_W-1:0]  packet_index;
        logic [SEQ_W-1:0]  packet_seq;
        logic [LEN_W-1:0]  packet_length;
        logic              ack_accepted;
        logic              timed_out;
        logic              done_res;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]   acked_count;
        logic [CNT_W-1:0]   next_index;
        logic [CNT_W-1:0]   packet_total;
        logic [TIMER_W-1:0] tick_timer;
    } state_t;

    typedef struct packed {
        logic [WIN_W-1:0]   window_size;
        logic [BYTES_W-1:0] total_bytes;
        logic [TOUT_W-1:0]  timeout_ticks;
    } cfg_t;

endpackage

### hdl/gbn_hdr_chk.sv
// Acknowledgment header check: flag byte, one's-complement checksum and expected sequence.
module gbn_hdr_chk (
    input  gbn_pkg::item_t           item,
    input  logic [gbn_pkg::SEQ_W-1:0] expect_seq,
    output logic                      hdr_ok
);
    import gbn_pkg::*;

    logic [WORD_W-1:0] word3;
    logic [WORD_W:0]   sum1;
    logic [WORD_W-1:0] fold1;
    logic [WORD_W:0]   sum2;
    logic [WORD_W-1:0] fold2;

    // End-around carry after each add; a fold never carries again.
    always_comb begin
        word3 = {item.ack_seq, item.ack_flags};
        sum1  = {1'b0, item.ack_length} + {1'b0, item.ack_checksum};
        fold1 = sum1[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, sum1[WORD_W]};
        sum2  = {1'b0, fold1} + {1'b0, word3};
        fold2 = sum2[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, sum2[WORD_W]};
        hdr_ok = (item.ack_flags == FLAG_ACK) && (fold2 == CSUM_OK) &&
                 (item.ack_seq == expect_seq);
    end

endmodule

### hdl/gbn_pass.sv
// One sender pass: start load, window test, packet length, header acceptance and timeout rewind.
module gbn_pass (
    input  gbn_pkg::item_t   item,
    input  gbn_pkg::state_t  state,
    input  gbn_pkg::cfg_t    cfg,
    output gbn_pkg::state_t  state_next,
    output gbn_pkg::result_t result
);
    import gbn_pkg::*;

    logic                  hdr_ok;
    logic [CNT_W-1:0]      in_flight;
    logic                  can_send;
    logic [CNT_W-1:0]      start_count;
    logic [BYTES_W:0]      start_byte;
    logic [BYTES_W:0]      rest_bytes;
    logic [LEN_W-1:0]      last_len;
    logic [TIMER_W-1:0]    timer_tick;
    logic [CNT_W-1:0]      acked_inc;

    gbn_hdr_chk u_hdr_chk (
        .item       (item),
        .expect_seq (state.acked_count[SEQ_W-1:0]),
        .hdr_ok     (hdr_ok)
    );

    always_comb begin
        // Packet count rounds up, capped at the index space.
        start_count = {1'b0, cfg.total_bytes[BYTES_W-1:PKT_SHIFT]} +
                      {{(CNT_W-1){1'b0}}, |cfg.total_bytes[PKT_SHIFT-1:0]};
        if (start_count > CNT_W'(MAX_PACKETS)) begin
            start_count = CNT_W'(MAX_PACKETS);
        end

        in_flight = state.next_index - state.acked_count;
        can_send  = (state.next_index < state.packet_total) &&
                    (in_flight < {{(CNT_W-WIN_W){1'b0}}, cfg.window_size});

        // Last packet carries the remainder, clamped to one packet.
        start_byte = {state.next_index, {PKT_SHIFT{1'b0}}};
        rest_bytes = {1'b0, cfg.total_bytes} - start_byte;
        if ({1'b0, cfg.total_bytes} <= start_byte) begin
            last_len = '0;
        end else if (rest_bytes > (BYTES_W+1)'(PACKET_BYTES)) begin
            last_len = LEN_W'(PACKET_BYTES);
        end else begin
            last_len = rest_bytes[LEN_W-1:0];
        end

        timer_tick = (state.tick_timer != TIMER_MAX) ? state.tick_timer + 1'b1
                                                     : state.tick_timer;
        acked_inc  = state.acked_count + 1'b1;

        state_next = state;
        result     = '0;

        if (item.func == FUNC_START) begin
            state_next.packet_total = start_count;
            state_next.acked_count  = '0;
            state_next.next_index   = '0;
            state_next.tick_timer   = '0;
        end else if (state.acked_count != state.packet_total) begin
            state_next.tick_timer = timer_tick;
            if (can_send) begin
                result.send_valid    = 1'b1;
                result.packet_index  = state.next_index[IDX_W-1:0];
                result.packet_seq    = state.next_index[SEQ_W-1:0];
                result.packet_length = (state.next_index + 1'b1 == state.packet_total)
                                       ? last_len : LEN_W'(PACKET_BYTES);
                if (state.next_index == state.acked_count) begin
                    state_next.tick_timer = '0;
                end
                state_next.next_index = state.next_index + 1'b1;
            end

            if (item.func == FUNC_ACK) begin
                if (hdr_ok) begin
                    result.ack_accepted    = 1'b1;
                    state_next.acked_count = acked_inc;
                    state_next.tick_timer  = '0;
                    if (state_next.next_index < acked_inc) begin
                        state_next.next_index = acked_inc;
                    end
                end
            end else if (state_next.tick_timer >
                         {{(TIMER_W-TOUT_W){1'b0}}, cfg.timeout_ticks}) begin
                // Go back to the oldest unacknowledged packet.
                result.timed_out      = 1'b1;
                state_next.next_index = state.acked_count;
            end
        end

        result.done_res = (state_next.acked_count == state_next.packet_total);
    end

endmodule

### hdl/go_back_n_sender_window_core.sv
// Top level of the go-back-n sender window core: input register, state, result register.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  s_tuser func, s_tdata header words
//  m_        out        m_tvalid/m_tready  m_tdata send request and status
//  cfg_      in         cfg_wr_en          cfg_addr, cfg_wr_data
//
// One request per cycle sustained while the m_ side accepts; a request passes the input
// register, then the result register; the pass logic between them is combinational.
// Reset loads the register defaults and clears the window state; no transfer is loaded.
// A stalled m_ side holds the result; the input register then fills and s_tready drops.
module go_back_n_sender_window_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // ack_length[15:0], ack_checksum[31:16], ack_flags[39:32],
                                   // ack_seq[47:40]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // send_valid[0], packet_index[14:1], packet_seq[22:15],
                                   // packet_length[33:23], ack_accepted[34], timed_out[35],
                                   // done_res[36], zero[39:37]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_wr_data
);
    import gbn_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    cfg_t    cfg_reg;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    gbn_pass u_pass (
        .item       (in_item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_size   <= WINDOW_RST;
            cfg_reg.total_bytes   <= TOTAL_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_WINDOW:  cfg_reg.window_size   <= cfg_wr_data[WIN_W-1:0];
                CFG_TOTAL:   cfg_reg.total_bytes   <= cfg_wr_data[BYTES_W-1:0];
                CFG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_wr_data[TOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.func         <= s_tuser;
            in_item_reg.ack_length   <= s_tdata[15:0];
            in_item_reg.ack_checksum <= s_tdata[31:16];
            in_item_reg.ack_flags    <= s_tdata[39:32];
            in_item_reg.ack_seq      <= s_tdata[47:40];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_res_reg.done_res,
                       out_res_reg.timed_out,
                       out_res_reg.ack_accepted,
                       out_res_reg.packet_length,
                       out_res_reg.packet_seq,
                       out_res_reg.packet_index,
                       out_res_reg.send_valid};

`ifndef SYNTH
    a_base_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.acked_count <= state_reg.packet_total)
        else $error("acked count passed packet total");

    a_next_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.next_index >= state_reg.acked_count) &&
        (state_reg.next_index <= state_reg.packet_total))
        else $error("next index outside base .. total");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    a_idle_send: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_res_reg.send_valid) |->
        (out_res_reg.packet_length == '0 && out_res_reg.packet_index == '0))
        else $error("packet fields set without a send");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("window state changed without a request");
`endif

endmodule

### sim/go_back_n_sender_window_core_tb.sv
// Self-checking bench for the go-back-n sender window core: directed and random requests.
module go_back_n_sender_window_core_tb;
    import gbn_pkg::*;

    localparam logic [1:0] FUNC_SPARE   = 2'd3;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         STALL_LIMIT  = 4000;
    localparam int         RANDOM_ITEMS = 1250;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata     = '0;   // ack_length[15:0], ack_checksum[31:16], ack_flags[39:32],
                                     // ack_seq[47:40]
    logic [1:0]  s_tuser     = '0;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;            // send_valid[0], packet_index[14:1], packet_seq[22:15],
                                     // packet_length[33:23], ack_accepted[34], timed_out[35],
                                     // done_res[36], zero[39:37]
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_addr    = '0;
    logic [23:0] cfg_wr_data = '0;

    go_back_n_sender_window_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    item_t   req_q[$];
    result_t send_plan_q[$];
    state_t  gen_state;
    state_t  chk_state;
    cfg_t    cfg_now;
    item_t   cur_item;
    int      err_count   = 0;
    int      idle_pct    = 10;
    bit      no_idle     = 1'b0;
    int      hold_token  = 0;
    int      hold_seen   = 0;
    int      tx_gap      = 0;
    int      rx_gap      = 0;
    int      rx_hold     = 0;
    int      stall_count = 0;
    int      res_count   = 0;

    function automatic logic [31:0] ones_add(logic [31:0] sum, logic [15:0] word);
        sum = sum + {16'd0, word};
        if (sum[31:16] != 16'd0)
            sum = {16'd0, sum[15:0]} + 32'd1;
        return sum;
    endfunction

    // One pass of the sender window: returns the send request and status it causes.
    function automatic result_t advance_window(inout state_t st, input cfg_t cf,
                                               input item_t it);
        result_t     r;
        int unsigned ack, nxt, tot, tmr, n, first_byte, plen;
        logic [31:0] sum;
        logic        hdr_ok;
        r   = '0;
        ack = 32'(st.acked_count);
        nxt = 32'(st.next_index);
        tot = 32'(st.packet_total);
        tmr = 32'(st.tick_timer);
        if (it.func == FUNC_START) begin
            n = (int'(cf.total_bytes) + PACKET_BYTES - 1) / PACKET_BYTES;
            if (n > MAX_PACKETS)
                n = MAX_PACKETS;
            tot = n;
            ack = 0;
            nxt = 0;
            tmr = 0;
        end else if (ack != tot) begin
            if (tmr < 32'(TIMER_MAX))
                tmr++;
            if (nxt < tot && nxt - ack < 32'(cf.window_size)) begin
                r.send_valid   = 1'b1;
                r.packet_index = nxt[IDX_W-1:0];
                r.packet_seq   = nxt[SEQ_W-1:0];
                plen = PACKET_BYTES;
                if (nxt + 1 == tot) begin
                    // last packet carries what is left of the file, clamped
                    first_byte = nxt * PACKET_BYTES;
                    if (32'(cf.total_bytes) <= first_byte)
                        plen = 0;
                    else if (32'(cf.total_bytes) - first_byte < PACKET_BYTES)
                        plen = 32'(cf.total_bytes) - first_byte;
                end
                r.packet_length = plen[LEN_W-1:0];
                if (nxt == ack)
                    tmr = 0;
                nxt++;
            end
            if (it.func == FUNC_ACK) begin
                sum = ones_add(ones_add(ones_add(32'd0, it.ack_length), it.ack_checksum),
                               {it.ack_seq, it.ack_flags});
                hdr_ok = (it.ack_flags == FLAG_ACK) && (sum[15:0] == CSUM_OK) &&
                         (it.ack_seq == ack[7:0]);
                if (hdr_ok) begin
                    r.ack_accepted = 1'b1;
                    ack++;
                    if (nxt < ack)
                        nxt = ack;
                    tmr = 0;
                end
            end else if (tmr > 32'(cf.timeout_ticks)) begin
                r.timed_out = 1'b1;
                nxt = ack;
            end
        end
        r.done_res      = (ack == tot);
        st.acked_count  = ack[CNT_W-1:0];
        st.next_index   = nxt[CNT_W-1:0];
        st.packet_total = tot[CNT_W-1:0];
        st.tick_timer   = tmr[TIMER_W-1:0];
        return r;
    endfunction

    function automatic item_t noise_item(logic [1:0] f);
        item_t it;
        it.func         = f;
        it.ack_length   = 16'($urandom);
        it.ack_checksum = 16'($urandom);
        it.ack_flags    = 8'($urandom);
        it.ack_seq      = 8'($urandom);
        return it;
    endfunction

    function automatic item_t good_ack(logic [7:0] seq);
        item_t       it;
        logic [31:0] sum;
        it.func       = FUNC_ACK;
        it.ack_length = 16'($urandom);
        it.ack_flags  = FLAG_ACK;
        it.ack_seq    = seq;
        sum = ones_add(ones_add(32'd0, it.ack_length), {seq, FLAG_ACK});
        it.ack_checksum = ~sum[15:0];
        return it;
    endfunction

    // kind 0: wrong flags, 1: corrupted checksum, 2: wrong sequence with valid checksum
    function automatic item_t broken_ack(logic [7:0] seq, int kind);
        item_t it;
        if (kind == 2) begin
            it = good_ack(seq + 8'($urandom_range(1, 255)));
        end else begin
            it = good_ack(seq);
            if (kind == 0)
                it.ack_flags = it.ack_flags ^ 8'($urandom_range(1, 255));
            else
                it.ack_checksum = it.ack_checksum ^ (16'd1 << $urandom_range(0, 15));
        end
        return it;
    endfunction

    task automatic queue_item(item_t it);
        void'(advance_window(gen_state, cfg_now, it));
        req_q.push_back(it);
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (req_q.size() != 0 || s_tvalid || send_plan_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_config(logic [7:0] win, logic [23:0] bytes, logic [15:0] tout);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_WINDOW;
        cfg_wr_data <= {16'd0, win};
        @(posedge aclk);
        cfg_addr    <= CFG_TOTAL;
        cfg_wr_data <= bytes;
        @(posedge aclk);
        cfg_addr    <= CFG_TIMEOUT;
        cfg_wr_data <= {8'd0, tout};
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_now.window_size   = win;
        cfg_now.total_bytes   = bytes;
        cfg_now.timeout_ticks = tout;
        @(negedge aclk);
    endtask

    task automatic random_config();
        logic [7:0]  win;
        logic [23:0] bytes;
        logic [15:0] tout;
        case ($urandom_range(0, 9))
            0: win = 8'd1;
            1: win = 8'd255;
            2: win = 8'd0;
            3: win = 8'($urandom_range(1, 32));
            default: win = 8'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 9))
            0: bytes = 24'd0;
            1: bytes = 24'hFFFFFF;
            2: bytes = 24'($urandom_range(1, 16) * PACKET_BYTES);
            default: bytes = 24'($urandom_range(1, 12 * PACKET_BYTES));
        endcase
        case ($urandom_range(0, 5))
            0: tout = 16'd1;
            1: tout = 16'hFFFF;
            default: tout = 16'($urandom_range(2, 40));
        endcase
        set_config(win, bytes, tout);
    endtask

    // Well-formed acks in order, mixed with broken headers, restarts, spare-code items and plain passes.
    task automatic run_phase(int n_items, bit restart, bit stress);
        int k, pick;
        if (stress)
            hold_token = hold_token + 1;
        if (restart)
            queue_item(noise_item(FUNC_START));
        for (k = 0; k < n_items; k++) begin
            if (stress && k == n_items / 2)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 3)
                queue_item(noise_item(FUNC_START));
            else if (pick < 45 && (gen_state.next_index != gen_state.acked_count ||
                                   $urandom_range(0, 7) == 0))
                queue_item(good_ack(gen_state.acked_count[7:0]));
            else if (pick < 57)
                queue_item(broken_ack(gen_state.acked_count[7:0], $urandom_range(0, 2)));
            else if (pick < 62)
                queue_item(noise_item(FUNC_SPARE));
            else
                queue_item(noise_item(FUNC_PASS));
        end
    endtask

    task automatic flag_error(string what, int unsigned got, int unsigned want);
        $display("mismatch on result %0d, %s: got %0d expected %0d",
                 res_count, what, got, want);
        err_count++;
    endtask

    // Request driver
    always @(posedge aclk) begin
        result_t planned;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                planned = advance_window(chk_state, cfg_now, cur_item);
                send_plan_q.push_back(planned);
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0 && !no_idle) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    cur_item = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_item.func;
                    s_tdata  <= {cur_item.ack_seq, cur_item.ack_flags,
                                 cur_item.ack_checksum, cur_item.ack_length};
                    if (!no_idle && $urandom_range(0, 99) < idle_pct)
                        tx_gap = $urandom_range(1, 12);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver backpressure
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (send_plan_q.size() == 0) begin
                    flag_error("result with nothing expected", 32'(m_tdata[36:0]), 32'd0);
                end else begin
                    want = send_plan_q.pop_front();
                    if (m_tdata[0] != want.send_valid)
                        flag_error("send_valid", 32'(m_tdata[0]), 32'(want.send_valid));
                    if (m_tdata[14:1] != want.packet_index)
                        flag_error("packet_index", 32'(m_tdata[14:1]),
                                   32'(want.packet_index));
                    if (m_tdata[22:15] != want.packet_seq)
                        flag_error("packet_seq", 32'(m_tdata[22:15]), 32'(want.packet_seq));
                    if (m_tdata[33:23] != want.packet_length)
                        flag_error("packet_length", 32'(m_tdata[33:23]),
                                   32'(want.packet_length));
                    if (m_tdata[34] != want.ack_accepted)
                        flag_error("ack_accepted", 32'(m_tdata[34]),
                                   32'(want.ack_accepted));
                    if (m_tdata[35] != want.timed_out)
                        flag_error("timed_out", 32'(m_tdata[35]), 32'(want.timed_out));
                    if (m_tdata[36] != want.done_res)
                        flag_error("done_res", 32'(m_tdata[36]), 32'(want.done_res));
                end
                res_count++;
            end
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                rx_hold   = HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0 && !no_idle) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 99) < idle_pct)
                    rx_gap = $urandom_range(1, 12);
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_count = 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_count = 0;
        end else begin
            stall_count++;
            if (stall_count >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int made;
        int n;
        int k;
        gen_state = '0;
        chk_state = '0;
        cfg_now   = '{window_size: WINDOW_RST, total_bytes: TOTAL_RST,
                      timeout_ticks: TIMEOUT_RST};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // No transfer loaded yet: requests only report done
        queue_item(noise_item(FUNC_PASS));
        queue_item(good_ack(8'd0));
        queue_item(noise_item(FUNC_SPARE));
        wait_drained();

        // Empty file
        set_config(8'd1, 24'd0, 16'd1);
        queue_item(noise_item(FUNC_START));
        queue_item(noise_item(FUNC_PASS));
        wait_drained();

        // Three packets, short last one; broken headers of each kind, then finish
        set_config(8'd255, 24'd2500, 16'hFFFF);
        queue_item(noise_item(FUNC_START));
        for (k = 0; k < 4; k++)
            queue_item(noise_item(FUNC_PASS));
        queue_item(good_ack(8'd0));
        queue_item(broken_ack(8'd1, 1));
        queue_item(broken_ack(8'd1, 0));
        queue_item(broken_ack(8'd1, 2));
        queue_item(good_ack(8'd1));
        queue_item(good_ack(8'd2));
        queue_item(noise_item(FUNC_PASS));
        wait_drained();

        // Largest file, zero window: a timeout without sends, then an ack ahead of next
        set_config(8'd0, 24'hFFFFFF, 16'd1);
        queue_item(noise_item(FUNC_START));
        queue_item(noise_item(FUNC_PASS));
        queue_item(noise_item(FUNC_PASS));
        queue_item(good_ack(8'd0));
        queue_item(noise_item(FUNC_PASS));
        wait_drained();

        made = 0;
        k    = 0;
        while (made < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: idle_pct = 0;
                1: idle_pct = 25;
                default: idle_pct = 10;
            endcase
            n = $urandom_range(20, 80);
            random_config();
            run_phase(n, $urandom_range(0, 3) != 0, k == 2);
            wait_drained();
            made += n;
            k++;
        end

        // Full rate on both sides to close out
        idle_pct = 0;
        no_idle  = 1'b1;
        for (k = 0; k < 3; k++) begin
            random_config();
            run_phase(40, 1'b1, 1'b0);
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
